// File: hw/rtl/acs_pkg.sv
package acs_pkg;

    localparam int unsigned MaskWidth = 12;

    typedef logic [MaskWidth-1:0] mask_t;
    typedef logic [2:0] upper_phase_t;
    typedef logic [1:0] lower_phase_t;

    // Sensor and actuator bit positions share one encoding.
    localparam mask_t B_STORE  = 12'h001;
    localparam mask_t B_DETAIL = 12'h002;
    localparam mask_t B_LEVL   = 12'h004;
    localparam mask_t B_LEVR   = 12'h008;
    localparam mask_t B_HEADL  = 12'h010;
    localparam mask_t B_HEADR  = 12'h020;
    localparam mask_t B_LOW    = 12'h040;
    localparam mask_t B_UP     = 12'h080;
    localparam mask_t B_C1G    = 12'h100;
    localparam mask_t B_C2G    = 12'h200;
    localparam mask_t B_C1O    = 12'h400;
    localparam mask_t B_C2O    = 12'h800;

    localparam logic KIND_START  = 1'b0;
    localparam logic KIND_REPORT = 1'b1;

    localparam upper_phase_t UP_PH0 = 3'd0;
    localparam upper_phase_t UP_PH1 = 3'd1;
    localparam upper_phase_t UP_PH2 = 3'd2;
    localparam upper_phase_t UP_PH3 = 3'd3;
    localparam upper_phase_t UP_PH4 = 3'd4;

    localparam lower_phase_t LO_PH0 = 2'd0;
    localparam lower_phase_t LO_PH1 = 2'd1;
    localparam lower_phase_t LO_PH2 = 2'd2;
    localparam lower_phase_t LO_PH3 = 2'd3;

    localparam mask_t        LATCH_RESET = B_DETAIL;
    localparam upper_phase_t UPPER_RESET = UP_PH1;
    localparam lower_phase_t LOWER_RESET = LO_PH0;

    typedef struct packed {
        mask_t        actuator_mask;
        logic         unrecognized;
        mask_t        latch_next;
        upper_phase_t upper_next;
        lower_phase_t lower_next;
    } rule_result_t;

endpackage

// File: hw/rtl/acs_rules.sv
module acs_rules (
    input  acs_pkg::mask_t        latch,
    input  acs_pkg::mask_t        events,
    input  acs_pkg::upper_phase_t upper_phase,
    input  acs_pkg::lower_phase_t lower_phase,
    output acs_pkg::rule_result_t result
);
    import acs_pkg::*;

    mask_t s;
    mask_t clr;
    mask_t act;
    logic  bad;
    upper_phase_t up_n;
    lower_phase_t lo_n;

    always_comb
    begin
        s    = latch | events;
        clr  = '0;
        act  = '0;
        bad  = 1'b0;
        up_n = upper_phase;
        lo_n = lower_phase;
        if ((s & (B_DETAIL | B_LEVL | B_HEADL)) == (B_DETAIL | B_LEVL | B_HEADL))
        begin
            clr = B_LEVL | B_HEADL;
            act = B_LOW;
        end
        else if ((s & (B_LEVR | B_HEADL)) == (B_LEVR | B_HEADL))
        begin
            clr = B_LEVR | B_HEADL;
            act = B_LOW;
        end
        else if ((s & B_HEADR) != '0)
        begin
            clr = B_HEADR;
            act = B_LOW;
        end
        else if ((s & B_C1O) != '0)
        begin
            clr = B_C1O;
            act = B_UP;
        end
        else if ((s & B_C1G) != '0)
        begin
            clr = B_C1G;
            act = B_UP;
        end
        else if ((s & B_C2O) != '0)
        begin
            clr = B_C2O;
            act = B_UP;
        end
        else if ((s & B_C2G) != '0)
        begin
            clr = B_C2G;
            act = B_UP;
        end
        else if (upper_phase == UP_PH0 && (s & (B_STORE | B_UP)) == (B_STORE | B_UP))
        begin
            clr  = B_STORE | B_UP;
            act  = B_LOW;
            up_n = UP_PH1;
        end
        else if (upper_phase == UP_PH1 && (s & B_UP) != '0)
        begin
            clr  = B_UP;
            act  = B_LEVL | B_HEADL;
            up_n = UP_PH2;
        end
        else if (upper_phase == UP_PH2 && (s & B_UP) != '0)
        begin
            clr  = B_UP;
            act  = B_HEADR;
            up_n = UP_PH3;
        end
        else if (upper_phase == UP_PH3 && (s & B_UP) != '0)
        begin
            clr  = B_UP;
            act  = B_DETAIL | B_LEVR | B_HEADL;
            up_n = UP_PH4;
        end
        else if (upper_phase == UP_PH4 && (s & B_UP) != '0)
        begin
            clr  = B_UP;
            act  = B_STORE | B_HEADR;
            up_n = UP_PH0;
        end
        else if ((s & B_LOW) != '0)
        begin
            clr  = B_LOW;
            lo_n = lower_phase + 2'd1;
            case (lower_phase)
                LO_PH0:  act = B_C1G;
                LO_PH1:  act = B_C2G;
                LO_PH2:  act = B_C1O;
                LO_PH3:  act = B_C2O;
                default: act = B_C2O;
            endcase
        end
        else
        begin
            bad = 1'b1;
        end
        result.actuator_mask = act;
        result.unrecognized  = bad;
        result.latch_next    = s & ~clr;
        result.upper_next    = up_n;
        result.lower_next    = lo_n;
    end

endmodule

// File: hw/rtl/arm_cell_sequencer.sv
// Channel   Direction  Handshake              Payload
// request   in         req_valid/req_ready    kind, sensor_events
// response  out        rsp_valid/rsp_ready    actuator_mask, unrecognized
//
// Each request is answered in the cycle after it is taken, and a new request can
// be taken every cycle while responses are taken; the rule check is one combinational
// pass into the response register. The response register is the only stall point:
// a request is taken while it is empty or being emptied. Reset sets the sensor latch
// to the detail ready bit, the upper phase to one and the lower phase to zero.
module arm_cell_sequencer (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 req_valid,
    output logic                 req_ready,
    input  logic                 kind,
    input  acs_pkg::mask_t       sensor_events,
    output logic                 rsp_valid,
    input  logic                 rsp_ready,
    output acs_pkg::mask_t       actuator_mask,
    output logic                 unrecognized
);
    import acs_pkg::*;

    mask_t        latch_reg;
    upper_phase_t upper_reg;
    lower_phase_t lower_reg;
    logic         rsp_valid_reg;
    logic         rsp_valid_next;
    mask_t        mask_reg;
    mask_t        mask_next;
    logic         bad_reg;
    logic         bad_next;
    rule_result_t rule;
    logic         req_fire;
    logic         report_fire;

    acs_rules u_rules (
        .latch       (latch_reg),
        .events      (sensor_events),
        .upper_phase (upper_reg),
        .lower_phase (lower_reg),
        .result      (rule)
    );

    assign req_ready   = !rsp_valid_reg || rsp_ready;
    assign req_fire    = req_valid && req_ready;
    assign report_fire = req_fire && (kind == KIND_REPORT);

    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (req_fire)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
        if (kind == KIND_START)
        begin
            mask_next = B_LOW;
            bad_next  = 1'b0;
        end
        else
        begin
            mask_next = rule.actuator_mask;
            bad_next  = rule.unrecognized;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            latch_reg     <= LATCH_RESET;
            upper_reg     <= UPPER_RESET;
            lower_reg     <= LOWER_RESET;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            rsp_valid_reg <= rsp_valid_next;
            if (report_fire)
            begin
                latch_reg <= rule.latch_next;
                upper_reg <= rule.upper_next;
                lower_reg <= rule.lower_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req_fire)
        begin
            mask_reg <= mask_next;
            bad_reg  <= bad_next;
        end
    end

    assign rsp_valid     = rsp_valid_reg;
    assign actuator_mask = mask_reg;
    assign unrecognized  = bad_reg;

    a_bad_zero_mask: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && unrecognized |-> actuator_mask == '0)
        else $error("Unrecognized response carries a nonzero mask.");

    a_upper_range: assert property (@(posedge clk) disable iff (!rst_n)
        upper_reg <= UP_PH4)
        else $error("Upper phase left its five-phase range.");

    a_detail_kept: assert property (@(posedge clk) disable iff (!rst_n)
        latch_reg[1] == 1'b1)
        else $error("Detail ready bit was cleared from the latch.");

    a_start_keeps_state: assert property (@(posedge clk) disable iff (!rst_n)
        req_fire && kind == KIND_START |=>
            $stable(latch_reg) && $stable(upper_reg) && $stable(lower_reg))
        else $error("Start request changed the sequencer state.");

endmodule
